### src/ctb_pkg.sv
`timescale 1ns / 1ps

package ctb_pkg;

  localparam int CMD_W   = 2;
  localparam int SEL_W   = 5;
  localparam int DUR_W   = 20;
  localparam int COUNT_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // one memory word: remaining ticks and the expiry flag
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               flag;
  } entry_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_QUERY = 1'b1
  } rmw_op_t;

endpackage

### src/ctb_ram.sv
`timescale 1ns / 1ps

module ctb_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 20,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/countdown_timer_bank.sv
`timescale 1ns / 1ps

// Bank of NUM_TIMERS countdown timers held in one memory word per timer.
// Input channel (in_valid/in_ready): in_cmd selects set, tick or query;
// in_timer_sel picks the timer, in_duration is the set duration in base
// units (loaded as duration / TICK_PERIOD, saturated to 17 bits).
// Output channel (out_valid/out_ready): one transaction per input
// transaction, out_expired carries the queried flag (cleared on read),
// 0 for every other command.
// One item is in flight at a time. Steps from input transaction to
// out_valid:
//   set: registered reciprocal multiply, then one write;
//   query: memory read, then write back with the flag cleared;
//   tick: one read-modify-write per timer through the
//   single memory, reads and writes pipelined one entry apart;
//   unused command, or set or query of an out-of-range timer: straight to the result.
// The result sits in an output register; the next input transaction is
// taken while it waits. If out_valid is still held when the next result
// is ready, that result waits internally until the register frees.
// Reset clears all timers at once through a per-entry valid bit; an
// entry never written since reset reads as count 0, flag 0.

module countdown_timer_bank #(
  parameter int NUM_TIMERS  = 20,
  parameter int TICK_PERIOD = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ctb_pkg::CMD_W-1:0] in_cmd,
  input  logic [ctb_pkg::SEL_W-1:0] in_timer_sel,
  input  logic [ctb_pkg::DUR_W-1:0] in_duration,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_expired
);

  import ctb_pkg::*;

  localparam int AW        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DIV_SHIFT = DUR_W + $clog2(TICK_PERIOD);
  localparam int RECIP_W   = DUR_W + 2;
  localparam int PROD_W    = DUR_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SHIFT) + TICK_PERIOD - 1) / TICK_PERIOD;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SETWR,
    S_QRD,
    S_TICK,
    S_DRAIN,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [SEL_W-1:0]      sel_r, sel_nxt;
  logic [DUR_W-1:0]      dur_r, dur_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic                  rmw_valid_r, rmw_valid_nxt;
  logic [AW-1:0]         rmw_addr_r, rmw_addr_nxt;
  rmw_op_t               rmw_op_r, rmw_op_nxt;
  logic                  res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_expired_r, out_expired_nxt;
  logic [NUM_TIMERS-1:0] vld_r, vld_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  entry_t                ram_wdata;
  logic [AW-1:0]         ram_raddr;
  entry_t                ram_rdata;

  entry_t                cur_entry;
  entry_t                upd_entry;
  logic [DUR_W-1:0]      quot;
  logic [COUNT_W-1:0]    quot_sat;
  logic                  in_sel_ok;
  logic [AW-1:0]         sel_addr;

  ctb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_sel_ok = ({1'b0, in_timer_sel} < (SEL_W + 1)'(NUM_TIMERS));
  assign sel_addr  = sel_r[AW-1:0];

  // duration / TICK_PERIOD by reciprocal; exact for all 20-bit durations
  assign quot     = DUR_W'(prod_r >> DIV_SHIFT);
  assign quot_sat = (|quot[DUR_W-1:COUNT_W]) ? COUNT_MAX : quot[COUNT_W-1:0];

  // entries not written since reset read as idle
  assign cur_entry = vld_r[rmw_addr_r] ? ram_rdata : '0;

  always_comb begin
    upd_entry = cur_entry;
    if (rmw_op_r == OP_TICK) begin
      if (cur_entry.count != '0) begin
        upd_entry.count = cur_entry.count - 1'b1;
        if (cur_entry.count == COUNT_W'(1)) begin
          upd_entry.flag = 1'b1;
        end
      end
    end else begin
      upd_entry.flag = 1'b0;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    sel_nxt         = sel_r;
    dur_nxt         = dur_r;
    prod_nxt        = prod_r;
    cnt_nxt         = cnt_r;
    rmw_valid_nxt   = 1'b0;
    rmw_addr_nxt    = rmw_addr_r;
    rmw_op_nxt      = rmw_op_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_expired_nxt = out_expired_r;
    vld_nxt         = vld_r;
    ram_we          = 1'b0;
    ram_waddr       = rmw_addr_r;
    ram_wdata       = upd_entry;
    ram_raddr       = cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // write-back half of the read-modify-write pipe
    if (rmw_valid_r) begin
      ram_we             = 1'b1;
      vld_nxt[rmw_addr_r] = 1'b1;
      if (rmw_op_r == OP_QUERY) begin
        res_nxt = cur_entry.flag;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sel_nxt = in_timer_sel;
          dur_nxt = in_duration;
          res_nxt = 1'b0;
          cnt_nxt = '0;
          unique case (cmd_t'(in_cmd))
            CMD_SET:   state_nxt = in_sel_ok ? S_MUL : S_RESP;
            CMD_TICK:  state_nxt = S_TICK;
            CMD_QUERY: state_nxt = in_sel_ok ? S_QRD : S_RESP;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(dur_r) * PROD_W'(RECIP);
        state_nxt = S_SETWR;
      end
      S_SETWR: begin
        ram_we            = 1'b1;
        ram_waddr         = sel_addr;
        ram_wdata         = '{count: quot_sat, flag: 1'b0};
        vld_nxt[sel_addr] = 1'b1;
        state_nxt         = S_RESP;
      end
      S_QRD: begin
        ram_raddr     = sel_addr;
        rmw_valid_nxt = 1'b1;
        rmw_addr_nxt  = sel_addr;
        rmw_op_nxt    = OP_QUERY;
        state_nxt     = S_DRAIN;
      end
      S_TICK: begin
        // read entry i while entry i-1 is written back
        ram_raddr     = cnt_r;
        rmw_valid_nxt = 1'b1;
        rmw_addr_nxt  = cnt_r;
        rmw_op_nxt    = OP_TICK;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_expired_nxt = res_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rmw_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rmw_valid_r <= rmw_valid_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
    end
    sel_r         <= sel_nxt;
    dur_r         <= dur_nxt;
    prod_r        <= prod_nxt;
    rmw_addr_r    <= rmw_addr_nxt;
    rmw_op_r      <= rmw_op_nxt;
    res_r         <= res_nxt;
    out_expired_r <= out_expired_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_expired = out_expired_r;

  // set write and pipe write share the one write port
  a_set_no_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETWR) |-> !rmw_valid_r)
    else $error("set write collides with read-modify-write");

  a_tick_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && rmw_valid_r) |-> (AW'(rmw_addr_r + 1'b1) == cnt_r))
    else $error("tick write-back not one entry behind read");

  a_drain_has_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> rmw_valid_r)
    else $error("drain without pending write-back");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("transaction accepted but block stayed idle");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, ram_waddr} < (AW + 1)'(NUM_TIMERS)))
    else $error("memory write beyond timer count");

endmodule

### verif/countdown_timer_bank_test.sv
`timescale 1ns / 1ps

module countdown_timer_bank_test;
  import ctb_pkg::*;

  localparam int NUM_TIMERS  = 20;
  localparam int TICK_PERIOD = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int N_DIRECTED       = 26;
  localparam int N_RANDOM         = 1424;
  localparam int NO_IDLE_FIRST    = 600;
  localparam int NO_IDLE_LAST     = 750;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_AT         = 900;
  localparam int SETTLE_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int MAX_PRINTED      = 20;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [SEL_W-1:0] sel;
    logic [DUR_W-1:0] dur;
    bit               typed;
    logic             want;
  } stim_row_t;

  typedef struct {
    int unsigned      seq;
    logic [CMD_W-1:0] cmd;
    logic [SEL_W-1:0] sel;
    logic             expired;
  } due_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd       = '0;
  logic [SEL_W-1:0]  in_timer_sel = '0;
  logic [DUR_W-1:0]  in_duration  = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic              out_expired;

  // shadow copy of the timer bank
  logic [COUNT_W-1:0] ticks_left [NUM_TIMERS];
  logic               fired      [NUM_TIMERS];

  due_t        expired_due[$];
  int unsigned n_sent      = 0;
  int unsigned n_got       = 0;
  int unsigned n_errors    = 0;
  int unsigned rx_wait     = 0;
  int unsigned quiet_count = 0;

  // directed part: typed answers where they are obvious, predictor elsewhere
  const stim_row_t directed [N_DIRECTED] = '{
    '{CMD_QUERY,  5'd0,  20'd0,       1'b1, 1'b0},  // nothing fired after reset
    '{CMD_QUERY,  5'd31, 20'd0,       1'b1, 1'b0},  // out-of-range query
    '{CMD_TICK,   5'd0,  20'd0,       1'b1, 1'b0},  // tick with all timers idle
    '{CMD_SET,    5'd19, 20'hFFFFF,   1'b1, 1'b0},  // longest duration, last timer
    '{CMD_SET,    5'd0,  20'd9,       1'b1, 1'b0},  // shorter than one tick period
    '{CMD_SET,    5'd1,  20'd10,      1'b1, 1'b0},  // exactly one tick
    '{CMD_SET,    5'd31, 20'd0,       1'b1, 1'b0},  // out-of-range set
    '{CMD_SET,    5'd20, 20'd10,      1'b1, 1'b0},
    '{CMD_TICK,   5'd31, 20'hFFFFF,   1'b1, 1'b0},
    '{CMD_QUERY,  5'd1,  20'd0,       1'b1, 1'b1},  // one-tick timer fired
    '{CMD_QUERY,  5'd1,  20'd0,       1'b1, 1'b0},  // cleared by the read
    '{CMD_QUERY,  5'd0,  20'd0,       1'b1, 1'b0},  // short duration never fires
    '{CMD_QUERY,  5'd20, 20'hFFFFF,   1'b1, 1'b0},
    '{CMD_UNUSED, 5'd1,  20'hFFFFF,   1'b1, 1'b0},
    '{CMD_UNUSED, 5'd0,  20'd0,       1'b1, 1'b0},
    '{CMD_SET,    5'd2,  20'd30,      1'b1, 1'b0},
    '{CMD_TICK,   5'd0,  20'd0,       1'b1, 1'b0},
    '{CMD_SET,    5'd2,  20'd29,      1'b1, 1'b0},  // reload while running
    '{CMD_TICK,   5'd0,  20'd0,       1'b1, 1'b0},
    '{CMD_QUERY,  5'd2,  20'd0,       1'b0, 1'b0},
    '{CMD_TICK,   5'd0,  20'd0,       1'b1, 1'b0},
    '{CMD_QUERY,  5'd2,  20'd0,       1'b0, 1'b0},
    '{CMD_SET,    5'd3,  20'd19,      1'b1, 1'b0},
    '{CMD_TICK,   5'd0,  20'd0,       1'b1, 1'b0},
    '{CMD_SET,    5'd3,  20'd5,       1'b1, 1'b0},  // reload drops a raised flag
    '{CMD_QUERY,  5'd3,  20'd0,       1'b0, 1'b0}
  };

  countdown_timer_bank #(
    .NUM_TIMERS  (NUM_TIMERS),
    .TICK_PERIOD (TICK_PERIOD)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_timer_sel (in_timer_sel),
    .in_duration  (in_duration),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_expired  (out_expired)
  );

  always #6 clk = ~clk;

  // updates the shadow bank and returns the expired bit of the transaction
  function automatic logic apply_timer_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic [SEL_W-1:0] sel,
                                           input logic [DUR_W-1:0] dur);
    logic [DUR_W-1:0] quot;
    logic             hit;
    hit  = 1'b0;
    quot = DUR_W'(dur / TICK_PERIOD);
    case (cmd)
      CMD_SET: begin
        if (sel < NUM_TIMERS) begin
          ticks_left[sel] = (quot > COUNT_MAX) ? COUNT_MAX : quot[COUNT_W-1:0];
          fired[sel]      = 1'b0;
        end
      end
      CMD_TICK: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (ticks_left[t] != '0) begin
            ticks_left[t] = ticks_left[t] - 1'b1;
            if (ticks_left[t] == '0) fired[t] = 1'b1;
          end
        end
      end
      CMD_QUERY: begin
        if (sel < NUM_TIMERS) begin
          hit        = fired[sel];
          fired[sel] = 1'b0;
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic int unsigned idle_cycles(input int unsigned idx);
    if (idx >= NO_IDLE_FIRST && idx < NO_IDLE_LAST) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_command(input logic [CMD_W-1:0] cmd,
                               input logic [SEL_W-1:0] sel,
                               input logic [DUR_W-1:0] dur,
                               input bit typed, input logic want);
    int unsigned gap;
    logic        predicted;
    due_t        d;
    gap = idle_cycles(n_sent);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd       = cmd;
    in_timer_sel = sel;
    in_duration  = dur;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = apply_timer_cmd(cmd, sel, dur);
    d.seq     = n_sent;
    d.cmd     = cmd;
    d.sel     = sel;
    d.expired = typed ? want : predicted;
    expired_due.push_back(d);
    n_sent++;
    @(negedge clk);
  endtask

  // receiver: ready drops after each transaction while rx_wait counts down
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (rx_wait != 0) begin
      out_ready = 1'b0;
      rx_wait--;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    due_t d;
    if (rst_n && out_valid && out_ready) begin
      if (expired_due.size() == 0) begin
        report_mismatch("result transaction with no command outstanding");
      end else begin
        d = expired_due.pop_front();
        if (out_expired !== d.expired)
          report_mismatch($sformatf("item %0d cmd %0d timer %0d: expired %b, want %b",
                                    d.seq, d.cmd, d.sel, out_expired, d.expired));
      end
      n_got++;
      rx_wait = (n_got == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : idle_cycles(n_got);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_count++;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("countdown_timer_bank_test: errors");
        $finish;
      end
    end else begin
      quiet_count = 0;
    end
  end

  initial begin
    int unsigned      pick;
    logic [CMD_W-1:0] cmd;
    logic [SEL_W-1:0] sel;
    logic [DUR_W-1:0] dur;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      ticks_left[t] = '0;
      fired[t]      = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      issue_command(directed[i].cmd, directed[i].sel, directed[i].dur,
                    directed[i].typed, directed[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      // sender idles until the block has drained everything
      if (n_sent == DRAIN_AT) begin
        in_valid = 1'b0;
        while (expired_due.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      sel  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(NUM_TIMERS, 31))
                                         : 5'($urandom_range(0, NUM_TIMERS - 1));
      case ($urandom_range(0, 9))
        0:       dur = 20'($urandom);
        1, 2:    dur = 20'($urandom_range(0, TICK_PERIOD - 1));
        default: dur = 20'($urandom_range(0, 25 * TICK_PERIOD));
      endcase
      if (pick < 30)      cmd = CMD_TICK;
      else if (pick < 62) cmd = CMD_SET;
      else if (pick < 95) cmd = CMD_QUERY;
      else                cmd = CMD_UNUSED;
      issue_command(cmd, sel, dur, 1'b0, 1'b0);
    end
    in_valid = 1'b0;

    while (expired_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("countdown_timer_bank_test: clean");
    end else begin
      $display("countdown_timer_bank_test: errors");
    end
    $finish;
  end

endmodule
